### src/assert_macros.svh
// Assertion macros shared by the ranging result processor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Concurrent check, skipped while reset is asserted.
`define TRP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Concurrent check that also runs during reset.
`define TRP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define TRP_ASSERT(lbl, clk, rstn, prop)
`define TRP_ASSERT_NR(lbl, clk, prop)

`endif

`endif

### src/trp_pkg.sv
// Types, constants and helper functions of the ranging result processor.
package trp_pkg;

  localparam int unsigned STATUS_W = 4;
  localparam int unsigned DATA16_W = 16;
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned RANGE_DIV_W = 16;
  localparam int unsigned RATE_DIV_W = 32;
  localparam int unsigned PROD_W = 27;
  localparam int unsigned GAIN_SHIFT = 11;
  localparam int unsigned IN_TDATA_W = 80;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [10:0] GAIN_FACTOR = 11'd2011;
  localparam logic [PROD_W-1:0] GAIN_ROUND = 27'h000_0400;
  localparam logic [15:0] SPAD_FALLBACK = 16'h8000;
  localparam logic [15:0] CLIP16 = 16'hFFFF;
  localparam logic [15:0] TARGET_RATE_RESET = 16'd2560;

  // Register index carried in the word-address bit of the bus.
  localparam logic REG_TARGET_RATE = 1'b0;

  // Raw status codes reported by the sensor.
  localparam logic [7:0] DEV_HW_FAIL_A = 8'd1;
  localparam logic [7:0] DEV_HW_FAIL_B = 8'd2;
  localparam logic [7:0] DEV_HW_FAIL_C = 8'd3;
  localparam logic [7:0] DEV_SIGNAL_FAIL = 8'd4;
  localparam logic [7:0] DEV_BOUNDS = 8'd5;
  localparam logic [7:0] DEV_SIGMA_FAIL = 8'd6;
  localparam logic [7:0] DEV_WRAP_FAIL = 8'd7;
  localparam logic [7:0] DEV_MIN_CLIPPED = 8'd8;
  localparam logic [7:0] DEV_RANGE_OK = 8'd9;
  localparam logic [7:0] DEV_XTALK_FAIL = 8'd12;
  localparam logic [7:0] DEV_MIN_RANGE = 8'd13;
  localparam logic [7:0] DEV_HW_FAIL_D = 8'd17;
  localparam logic [7:0] DEV_SYNC = 8'd18;

  typedef enum logic [STATUS_W-1:0] {
    RS_VALID    = 4'd0,
    RS_SIGMA    = 4'd1,
    RS_SIGNAL   = 4'd2,
    RS_MINCLIP  = 4'd3,
    RS_BOUNDS   = 4'd4,
    RS_HW       = 4'd5,
    RS_NOWRAP   = 4'd6,
    RS_WRAP     = 4'd7,
    RS_XTALK    = 4'd8,
    RS_SYNC     = 4'd9,
    RS_MINRANGE = 4'd10,
    RS_NONE     = 4'd11
  } meas_status_t;

  // Fields that ride alongside the divider chains.
  typedef struct packed {
    logic         fallback;
    meas_status_t status;
    logic [15:0]  dist_mm;
    logic [15:0]  peak_rate;
    logic [15:0]  ambient_rate;
  } trp_side_t;

  localparam int unsigned SIDE_W = $bits(trp_side_t);

  function automatic meas_status_t map_status(logic [7:0] dev, logic [7:0] stream);
    meas_status_t rs;
    unique case (dev)
      DEV_HW_FAIL_A, DEV_HW_FAIL_B, DEV_HW_FAIL_C, DEV_HW_FAIL_D: rs = RS_HW;
      DEV_SIGNAL_FAIL: rs = RS_SIGNAL;
      DEV_BOUNDS:      rs = RS_BOUNDS;
      DEV_SIGMA_FAIL:  rs = RS_SIGMA;
      DEV_WRAP_FAIL:   rs = RS_WRAP;
      DEV_MIN_CLIPPED: rs = RS_MINCLIP;
      DEV_RANGE_OK:    rs = (stream == 8'd0) ? RS_NOWRAP : RS_VALID;
      DEV_XTALK_FAIL:  rs = RS_XTALK;
      DEV_MIN_RANGE:   rs = RS_MINRANGE;
      DEV_SYNC:        rs = RS_SYNC;
      default:         rs = RS_NONE;
    endcase
    return rs;
  endfunction

endpackage

### src/trp_div_cell.sv
// One restoring-division cell: resolves one quotient bit per transfer.
`include "assert_macros.svh"

module trp_div_cell
  import trp_pkg::*;
#(
  parameter int unsigned DVD_W  = DIVIDEND_W,
  parameter int unsigned DVS_W  = RANGE_DIV_W,
  parameter int unsigned SIDE_WD = SIDE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [DVS_W-1:0]   in_rem,
  input  logic [DVD_W-1:0]   in_dvd,
  input  logic [DVD_W-1:0]   in_quo,
  input  logic [DVS_W-1:0]   in_dvs,
  input  logic [SIDE_WD-1:0] in_side,
  output logic               out_valid,
  output logic [DVS_W-1:0]   out_rem,
  output logic [DVD_W-1:0]   out_dvd,
  output logic [DVD_W-1:0]   out_quo,
  output logic [DVS_W-1:0]   out_dvs,
  output logic [SIDE_WD-1:0] out_side
);

  logic               valid_r;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0]   dvd_r, quo_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [SIDE_WD-1:0] side_r;
  logic [DVS_W:0]     trial;
  logic [DVS_W:0]     diff;
  logic               ge;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial   = {in_rem, in_dvd[DVD_W-1]};
    ge      = (trial >= {1'b0, in_dvs});
    diff    = trial - {1'b0, in_dvs};
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {in_dvd[DVD_W-2:0], 1'b0};
      quo_r  <= {in_quo[DVD_W-2:0], ge};
      dvs_r  <= in_dvs;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_dvd   = dvd_r;
  assign out_quo   = quo_r;
  assign out_dvs   = dvs_r;
  assign out_side  = side_r;

  `TRP_ASSERT(a_rem_below_divisor, clk, rst_n, (en && in_valid && (in_rem < in_dvs)) |=> (rem_r < dvs_r))

endmodule

### src/trp_div_chain.sv
// Row of division cells that yields one full quotient per transfer.
module trp_div_chain
  import trp_pkg::*;
#(
  parameter int unsigned DVD_W   = DIVIDEND_W,
  parameter int unsigned DVS_W   = RANGE_DIV_W,
  parameter int unsigned SIDE_WD = SIDE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [DVD_W-1:0]   in_dividend,
  input  logic [DVS_W-1:0]   in_divisor,
  input  logic [SIDE_WD-1:0] in_side,
  output logic               out_valid,
  output logic [DVD_W-1:0]   out_quotient,
  output logic [SIDE_WD-1:0] out_side
);

  logic               v_s    [0:DVD_W];
  logic [DVS_W-1:0]   rem_s  [0:DVD_W];
  logic [DVD_W-1:0]   dvd_s  [0:DVD_W];
  logic [DVD_W-1:0]   quo_s  [0:DVD_W];
  logic [DVS_W-1:0]   dvs_s  [0:DVD_W];
  logic [SIDE_WD-1:0] side_s [0:DVD_W];

  assign v_s[0]    = in_valid;
  assign rem_s[0]  = '0;
  assign dvd_s[0]  = in_dividend;
  assign quo_s[0]  = '0;
  assign dvs_s[0]  = in_divisor;
  assign side_s[0] = in_side;

  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    trp_div_cell #(
      .DVD_W  (DVD_W),
      .DVS_W  (DVS_W),
      .SIDE_WD(SIDE_WD)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v_s[i]),
      .in_rem   (rem_s[i]),
      .in_dvd   (dvd_s[i]),
      .in_quo   (quo_s[i]),
      .in_dvs   (dvs_s[i]),
      .in_side  (side_s[i]),
      .out_valid(v_s[i+1]),
      .out_rem  (rem_s[i+1]),
      .out_dvd  (dvd_s[i+1]),
      .out_quo  (quo_s[i+1]),
      .out_dvs  (dvs_s[i+1]),
      .out_side (side_s[i+1])
    );
  end

  assign out_valid    = v_s[DVD_W];
  assign out_quotient = quo_s[DVD_W];
  assign out_side     = side_s[DVD_W];

endmodule

### src/tof_ranging_result_processor.sv
// Top level of the time-of-flight ranging result processor.
//
// Each measurement record that arrives on the in_ stream yields exactly one
// result on the out_ stream. The block takes one record per clock cycle for
// as long as the result side keeps taking transfers, and every result passes
// through one input stage, two rows of 32 division cells (one quotient bit
// each) and one output register. When the result side stalls, the whole
// pipeline holds in place, and in_tready follows out_tready while a result
// is waiting. target_rate is written through the APB-style cfg_ port and
// should only change while no record is in flight.
`include "assert_macros.svh"

module tof_ranging_result_processor
  import trp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration port.
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready,
  // Record stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // From bit 0: device status[8], stream counter[8], effective_spads[16],
  // ambient_rate[16], peak_rate[16], raw_range[16].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // From bit 0: corrected distance[16], mapped status[4], requested_spads[16],
  // peak_rate_out[16], ambient_rate_out[16], then four zero bits.
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic        adv;
  logic [15:0] target_rate_r;

  // The pipeline moves as one whenever the output register can take a result.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Register access; only the word-address bit selects the register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TARGET_RATE) ?
                      {16'h0000, target_rate_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_rate_r <= TARGET_RATE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_TARGET_RATE)) begin
      target_rate_r <= cfg_pwdata[15:0];
    end
  end

  // Input fields.
  logic [7:0]  dev_status;
  logic [7:0]  strm_cnt;
  logic [15:0] eff_spads;
  logic [15:0] amb_rate;
  logic [15:0] pk_rate;
  logic [15:0] raw_range;

  assign dev_status = in_tdata[7:0];
  assign strm_cnt   = in_tdata[15:8];
  assign eff_spads  = in_tdata[31:16];
  assign amb_rate   = in_tdata[47:32];
  assign pk_rate    = in_tdata[63:48];
  assign raw_range  = in_tdata[79:64];

  // Input stage: gain correction, status mapping, the zero-SPAD fallback flag and the clipped rate sum.
  logic [16:0]       rate_sum;
  logic [15:0]       total_nxt;
  logic [PROD_W-1:0] gain_prod;
  trp_side_t         side_nxt;

  always_comb begin
    rate_sum  = {1'b0, pk_rate} + {1'b0, amb_rate};
    total_nxt = rate_sum[16] ? CLIP16 : rate_sum[15:0];
    gain_prod = PROD_W'(raw_range) * PROD_W'(GAIN_FACTOR) + GAIN_ROUND;
    side_nxt.fallback     = (eff_spads == 16'h0000);
    side_nxt.status       = map_status(dev_status, strm_cnt);
    side_nxt.dist_mm      = gain_prod[PROD_W-1:GAIN_SHIFT];
    side_nxt.peak_rate    = pk_rate;
    side_nxt.ambient_rate = amb_rate;
  end

  logic        s0_valid_r;
  logic [15:0] s0_total_r;
  logic [15:0] s0_spads_r;
  trp_side_t   s0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_total_r <= total_nxt;
      s0_spads_r <= eff_spads;
      s0_side_r  <= side_nxt;
    end
  end

  // First division row: rate per SPAD, (total << 16) / effective_spads.
  logic                  d1_valid;
  logic [DIVIDEND_W-1:0] d1_quo;
  logic [SIDE_W-1:0]     d1_side_bits;

  trp_div_chain #(
    .DVD_W  (DIVIDEND_W),
    .DVS_W  (RANGE_DIV_W),
    .SIDE_WD(SIDE_W)
  ) u_div_per_spad (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (s0_valid_r),
    .in_dividend ({s0_total_r, 16'h0000}),
    .in_divisor  (s0_spads_r),
    .in_side     (s0_side_r),
    .out_valid   (d1_valid),
    .out_quotient(d1_quo),
    .out_side    (d1_side_bits)
  );

  // A zero rate per SPAD also forces the fallback request.
  trp_side_t d1_side, d2_in_side;

  always_comb begin
    d1_side             = trp_side_t'(d1_side_bits);
    d2_in_side          = d1_side;
    d2_in_side.fallback = d1_side.fallback || (d1_quo == '0);
  end

  // Second division row: (target_rate << 16) / rate per SPAD.
  logic                  d2_valid;
  logic [DIVIDEND_W-1:0] d2_quo;
  logic [SIDE_W-1:0]     d2_side_bits;

  trp_div_chain #(
    .DVD_W  (DIVIDEND_W),
    .DVS_W  (RATE_DIV_W),
    .SIDE_WD(SIDE_W)
  ) u_div_request (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (d1_valid),
    .in_dividend ({target_rate_r, 16'h0000}),
    .in_divisor  (d1_quo),
    .in_side     (d2_in_side),
    .out_valid   (d2_valid),
    .out_quotient(d2_quo),
    .out_side    (d2_side_bits)
  );

  // Output register: fallback, saturation and packing of the result.
  trp_side_t   d2_side;
  logic [15:0] request_nxt;

  always_comb begin
    d2_side = trp_side_t'(d2_side_bits);
    if (d2_side.fallback) begin
      request_nxt = SPAD_FALLBACK;
    end else if (d2_quo[31:16] != 16'h0000) begin
      request_nxt = CLIP16;
    end else begin
      request_nxt = d2_quo[15:0];
    end
  end

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {4'h0, d2_side.ambient_rate, d2_side.peak_rate, request_nxt,
                      d2_side.status, d2_side.dist_mm};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `TRP_ASSERT_NR(a_no_result_after_reset, clk, !rst_n |=> !out_tvalid)
  `TRP_ASSERT(a_status_in_range, clk, rst_n, out_tvalid |-> (out_tdata[19:16] <= RS_NONE))
  `TRP_ASSERT(a_range_gain_bound, clk, rst_n, out_tvalid |-> (out_tdata[15:0] <= 16'd64351))

endmodule

### bench/tof_ranging_result_processor_tb.sv
// Self-checking testbench for the time-of-flight ranging result processor.
`timescale 1ns / 100ps

module tof_ranging_result_processor_tb
  import trp_pkg::*;
();

  // The only register sits at byte address zero. Its index travels in the
  // word-address bit of the bus.
  localparam logic [CFG_ADDR_W-1:0] TARGET_RATE_ADDR = {REG_TARGET_RATE, 2'b00};

  // Longest gap that either side inserts before one transfer.
  localparam int MAX_GAP = 8;
  // The tail wait is longer than the pipeline so that a stray extra result is
  // still caught.
  localparam int DRAIN_CYCLES = 80;

  // Input record, packed so that the last field, device_status, lands in the lowest bits.
  typedef struct packed {
    logic [15:0] raw_range;
    logic [15:0] peak_rate;
    logic [15:0] ambient_rate;
    logic [15:0] effective_spads;
    logic [7:0]  strm_cnt;
    logic [7:0]  device_status;
  } record_t;

  // Result item, with the same packing as out_tdata.
  typedef struct packed {
    logic [3:0]   pad;
    logic [15:0]  ambient_rate;
    logic [15:0]  peak_rate;
    logic [15:0]  requested_spads;
    meas_status_t meas_status;
    logic [15:0]  dist_mm;
  } ranging_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predictor state. This is a copy of the target_rate register.
  logic [15:0]     target_rate_model;
  // Results predicted for accepted records, oldest first.
  ranging_result_t pending_results[$];

  int mismatches;
  int records_sent;
  int results_checked;
  int cfg_writes;
  int input_stalls;

  // Per-side switches for random gaps. A nonzero hold count makes the result
  // side refuse transfers until it has counted down to zero.
  bit tx_gaps_on;
  bit rx_gaps_on;
  int rx_hold_cycles;
  // Set at each rising edge at which a result transfer happened.
  bit out_fire;

  tof_ranging_result_processor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predicted result of one record under a given target rate.
  function automatic ranging_result_t predict_ranging(record_t rec, logic [15:0] target);
    ranging_result_t res;
    logic [31:0]     scaled;
    logic [16:0]     rate_sum;
    logic [15:0]     total;
    logic [31:0]     per_spad;
    logic [31:0]     spads_needed;
    res = '0;
    // Apply the gain of 2011/2048 and round to the nearest millimeter.
    scaled = 32'(rec.raw_range) * 32'(GAIN_FACTOR) + 32'(GAIN_ROUND);
    res.dist_mm = scaled[GAIN_SHIFT +: 16];

    case (rec.device_status)
      DEV_HW_FAIL_A, DEV_HW_FAIL_B, DEV_HW_FAIL_C, DEV_HW_FAIL_D: res.meas_status = RS_HW;
      DEV_SIGNAL_FAIL: res.meas_status = RS_SIGNAL;
      DEV_BOUNDS:      res.meas_status = RS_BOUNDS;
      DEV_SIGMA_FAIL:  res.meas_status = RS_SIGMA;
      DEV_WRAP_FAIL:   res.meas_status = RS_WRAP;
      DEV_MIN_CLIPPED: res.meas_status = RS_MINCLIP;
      DEV_RANGE_OK:    res.meas_status = (rec.strm_cnt == 8'd0) ? RS_NOWRAP : RS_VALID;
      DEV_XTALK_FAIL:  res.meas_status = RS_XTALK;
      DEV_MIN_RANGE:   res.meas_status = RS_MINRANGE;
      DEV_SYNC:        res.meas_status = RS_SYNC;
      default:         res.meas_status = RS_NONE;
    endcase

    // The total rate is clipped to 16 bits. It is divided per SPAD, and the
    // target is then divided by that rate. Either divisor being zero makes
    // the block fall back to the mid-scale request.
    rate_sum = {1'b0, rec.peak_rate} + {1'b0, rec.ambient_rate};
    total = rate_sum[16] ? CLIP16 : rate_sum[15:0];
    if (rec.effective_spads == 16'd0) begin
      res.requested_spads = SPAD_FALLBACK;
    end else begin
      per_spad = {total, 16'h0000} / {16'h0000, rec.effective_spads};
      if (per_spad == 32'd0) begin
        res.requested_spads = SPAD_FALLBACK;
      end else begin
        spads_needed = {target, 16'h0000} / per_spad;
        res.requested_spads = (spads_needed > 32'(CLIP16)) ? CLIP16 : spads_needed[15:0];
      end
    end

    res.peak_rate = rec.peak_rate;
    res.ambient_rate = rec.ambient_rate;
    return res;
  endfunction

  // A 16-bit value with its magnitude drawn first, so that small, mid and
  // full-scale values all appear often and every bit still toggles.
  function automatic logic [15:0] rand_field16();
    logic [15:0] width_mask;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: begin
        width_mask = 16'hFFFF >> $urandom_range(0, 15);
        return 16'($urandom) & width_mask;
      end
    endcase
  endfunction

  // Most status codes fall among the ones that the block maps. A fraction
  // cover the whole byte, and zero stream counts are frequent.
  function automatic record_t random_record();
    record_t rec;
    rec.device_status = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
    rec.strm_cnt = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
    rec.effective_spads = rand_field16();
    rec.ambient_rate = rand_field16();
    rec.peak_rate = rand_field16();
    rec.raw_range = rand_field16();
    return rec;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s: expected 0x%04h, got 0x%04h", name, want, got));
    end
  endfunction

  // Offer one record after a random gap, if gaps are on, and wait for its
  // transfer. The predicted result is queued at the edge that accepts it.
  task automatic send_record(record_t rec);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = rec;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_ranging(rec, target_rate_model));
    records_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Every record causes one result, so the block is idle once the queue
  // has emptied.
  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Read target_rate and compare it with the model's copy.
  task automatic check_target_readback();
    logic [CFG_DATA_W-1:0] readback;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = TARGET_RATE_ADDR;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (readback !== CFG_DATA_W'(target_rate_model)) begin
      note_mismatch($sformatf("target_rate readback: expected 0x%08h, got 0x%08h",
                              CFG_DATA_W'(target_rate_model), readback));
    end
  endtask

  // Write target_rate through a setup and an access cycle, then read it back.
  task automatic set_target_rate(logic [15:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = TARGET_RATE_ADDR;
    cfg_pwdata = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    target_rate_model = value;
    cfg_writes++;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    check_target_readback();
  endtask

  // The register must come out of reset at its documented value.
  task automatic test_reset_value();
    check_target_readback();
  endtask

  // Directed records cover every status code and the corner cases of the
  // SPAD request. The concatenations list the fields from raw_range down to
  // device_status.
  task automatic test_directed();
    record_t rec;
    for (int code = 0; code <= 19; code++) begin
      rec.device_status = 8'(code);
      rec.strm_cnt = 8'(code * 13 + 1);
      rec.effective_spads = 16'(code * 3277 + 1);
      rec.ambient_rate = 16'(code * 1111);
      rec.peak_rate = 16'(code * 2999);
      rec.raw_range = 16'(code * 3449);
      send_record(rec);
    end
    // A good range without the wrap check, together with the largest raw range.
    send_record({16'hFFFF, 16'h0280, 16'h0040, 16'h0A00, 8'd0, DEV_RANGE_OK});
    // Zero effective SPAD count.
    send_record({16'h1234, 16'h0800, 16'h0100, 16'h0000, 8'd7, DEV_RANGE_OK});
    // Both rates zero, so the rate per SPAD is zero.
    send_record({16'h0001, 16'h0000, 16'h0000, 16'h0100, 8'd1, DEV_SIGMA_FAIL});
    // A tiny rate per SPAD makes the request saturate.
    send_record({16'h8000, 16'h0001, 16'h0000, 16'hFFFF, 8'd2, DEV_SYNC});
    // All ones. The rate sum clips to 16 bits and the status code is unmapped.
    send_record({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF});
    idle_input();
    wait_for_results();
  endtask

  // Several settings of target_rate, the extremes among them. Each setting
  // is followed by a batch of random records, and the block is drained
  // before every write.
  task automatic test_target_sweep();
    logic [15:0] settings [4];
    settings[0] = 16'h0000;
    settings[1] = 16'hFFFF;
    settings[2] = 16'h0001;
    settings[3] = 16'($urandom);
    foreach (settings[i]) begin
      set_target_rate(settings[i]);
      repeat (40) send_record(random_record());
      idle_input();
      wait_for_results();
    end
    set_target_rate(TARGET_RATE_RESET);
  endtask

  // The result side holds off for a long stretch while records keep coming
  // back to back. The pipeline fills up and in_tready has to drop.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 300;
    repeat (150) send_record(random_record());
    idle_input();
    wait_for_results();
    tx_gaps_on = 1'b1;
  endtask

  // Random traffic in blocks. The block index switches the gaps of each side,
  // and one block runs with no gaps at all. After each block the sender pauses
  // until every result has arrived. Some pauses carry a new target rate.
  task automatic test_random_traffic();
    for (int blk = 0; blk < 7; blk++) begin
      tx_gaps_on = blk[0] == 1'b0;
      rx_gaps_on = blk[1] == 1'b0;
      repeat (100) send_record(random_record());
      idle_input();
      wait_for_results();
      if ($urandom_range(0, 1) == 1) begin
        set_target_rate(rand_field16());
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // While its gaps are on, the result side picks a fresh gap after every transfer. A requested
  // hold-off is counted down here, one cycle at a time.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_fire && rx_gaps_on) begin
        stall_left = $urandom_range(0, MAX_GAP);
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Each result transfer is compared field by field with the oldest
  // predicted result.
  always @(posedge clk) begin : result_check
    ranging_result_t got;
    ranging_result_t want;
    out_fire = rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && !in_tready) begin
      input_stalls++;
    end
    if (out_fire) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result 0x%018h with no record pending", out_tdata));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("dist_mm", got.dist_mm, want.dist_mm);
        check_field("meas_status", 16'(got.meas_status), 16'(want.meas_status));
        check_field("requested_spads", got.requested_spads, want.requested_spads);
        check_field("peak_rate_out", got.peak_rate, want.peak_rate);
        check_field("ambient_rate_out", got.ambient_rate, want.ambient_rate);
        check_field("padding", 16'(got.pad), 16'(want.pad));
      end
    end
  end

  // A correct run ends well before this limit, even with every gap and stall
  // at its longest.
  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d results still pending.", pending_results.size());
    $display("tof_ranging_result_processor verification failed");
    $finish;
  end

  initial begin : run_tests
    mismatches = 0;
    records_sent = 0;
    results_checked = 0;
    cfg_writes = 0;
    input_stalls = 0;
    rx_hold_cycles = 0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    target_rate_model = TARGET_RATE_RESET;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_value();
    test_directed();
    test_target_sweep();
    test_backpressure();
    test_random_traffic();

    // Wait past the pipeline latency so that any extra result shows up.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d records and %0d checked results over %0d target_rate writes.",
             records_sent, results_checked, cfg_writes);
    $display("Input was held back on %0d cycles; %0d mismatches, %0d results left over.",
             input_stalls, mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tof_ranging_result_processor verification clean");
    end else begin
      $display("tof_ranging_result_processor verification failed");
    end
    $finish;
  end

endmodule
